// File: hdl/paft_pkg.sv
// paft_pkg: shared types, codes and constants of the PWM audio FIFO timer.
// No dependencies; used by paft_ctrl, paft_dp and pwm_audio_fifo_timer_core.
package paft_pkg;

   localparam int DEF_QUEUE_DEPTH     = 3;
   localparam int DEF_MAX_TICK_CYCLES = 32;
   localparam int RESULT_LIMIT        = 32;

   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [2:0] REG_CTRL  = 3'd0;
   localparam logic [2:0] REG_CYCLE = 3'd1;
   localparam logic [2:0] REG_LEFT  = 3'd2;
   localparam logic [2:0] REG_RIGHT = 3'd3;
   localparam logic [2:0] REG_MONO  = 3'd4;

   localparam logic [11:0] CTRL_MASK   = 12'hF8F;
   localparam int          CTRL_RTP    = 7;
   localparam logic [12:0] ACC_MAX     = 13'h1FFF;
   localparam logic [15:0] STAT_FULL   = 16'h8000;
   localparam logic [15:0] STAT_EMPTY  = 16'h4000;
   localparam logic [4:0]  DIV_MAX     = 5'd16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  reg_offset;
      logic [15:0] write_data;
      logic [5:0]  cycles;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] read_data;
      logic [11:0] left_sample;
      logic [11:0] right_sample;
      logic        timer_irq;
      logic        dma_request;
      logic        last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PERIOD
   } state_type;

   typedef struct packed {
      logic capture;
      logic do_write;
      logic load_read;
      logic tick_start;
      logic emit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       enabled;
      logic       more;
      logic       more_after;
      logic       out_free;
   } sts_type;

   function automatic logic [4:0] div_reload(input logic [3:0] tm);
      return (tm == 4'd0) ? DIV_MAX : {1'b0, tm};
   endfunction

endpackage

// File: hdl/paft_ctrl.sv
// paft_ctrl: sequencer for register accesses and tick period emission.
// Depends on paft_pkg; drives commands into paft_dp.
module paft_ctrl #(
   parameter int MAX_TICK_CYCLES = paft_pkg::DEF_MAX_TICK_CYCLES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  paft_pkg::sts_type sts,
   output paft_pkg::cmd_type cmd
);

   localparam int LIMIT = (MAX_TICK_CYCLES < paft_pkg::RESULT_LIMIT) ?
                          MAX_TICK_CYCLES : paft_pkg::RESULT_LIMIT;
   localparam int N_W   = $clog2(LIMIT + 1);
   localparam logic [N_W:0] LIMIT_V = (N_W + 1)'(LIMIT);

   paft_pkg::state_type state_ff, state_in;
   logic [N_W-1:0]      n_ff, n_in;
   logic [N_W:0]        n_inc;
   logic                has_room, room_after, go;

   assign n_inc      = {1'b0, n_ff} + 1'b1;
   assign has_room   = {1'b0, n_ff} < LIMIT_V;
   assign room_after = n_inc < LIMIT_V;
   assign go         = sts.more && has_room;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         paft_pkg::ST_IDLE: begin
            if (req_valid) state_in = paft_pkg::ST_EXEC;
         end
         paft_pkg::ST_EXEC: begin
            case (sts.kind)
               paft_pkg::KIND_READ: begin
                  if (sts.out_free) state_in = paft_pkg::ST_IDLE;
               end
               paft_pkg::KIND_TICK: begin
                  state_in = sts.enabled ? paft_pkg::ST_PERIOD : paft_pkg::ST_IDLE;
               end
               default: state_in = paft_pkg::ST_IDLE;
            endcase
         end
         paft_pkg::ST_PERIOD: begin
            if (!go) state_in = paft_pkg::ST_IDLE;
            else if (sts.out_free && !(sts.more_after && room_after))
               state_in = paft_pkg::ST_IDLE;
         end
         default: state_in = paft_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         paft_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         paft_pkg::ST_EXEC: begin
            case (sts.kind)
               paft_pkg::KIND_READ:  cmd.load_read  = sts.out_free;
               paft_pkg::KIND_WRITE: cmd.do_write   = 1'b1;
               paft_pkg::KIND_TICK:  cmd.tick_start = sts.enabled;
               default: ;
            endcase
         end
         paft_pkg::ST_PERIOD: begin
            cmd.emit = go && sts.out_free;
            cmd.last = !(sts.more_after && room_after);
         end
         default: ;
      endcase
   end

   always_comb begin
      n_in = n_ff;
      if (cmd.tick_start) n_in = '0;
      else if (cmd.emit)  n_in = n_inc[N_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= paft_pkg::ST_IDLE;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
      end
   end

endmodule

// File: hdl/paft_dp.sv
// paft_dp: register file, sample queues, cycle accumulator, divider and result register.
// Depends on paft_pkg; commanded by paft_ctrl.
module paft_dp #(
   parameter int QUEUE_DEPTH     = paft_pkg::DEF_QUEUE_DEPTH,
   parameter int MAX_TICK_CYCLES = paft_pkg::DEF_MAX_TICK_CYCLES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  paft_pkg::req_word_type req_word,
   input  paft_pkg::cmd_type      cmd,
   output paft_pkg::sts_type      sts,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output paft_pkg::rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [6:0]       CYC_MAX  = 7'(MAX_TICK_CYCLES);

   paft_pkg::req_word_type req_ff;
   logic [11:0]            ctrl_ff, ctrl_in;
   logic [11:0]            cycle_ff, cycle_in;
   logic [11:0]            q_ff [2][QUEUE_DEPTH];
   logic [11:0]            q_in [2][QUEUE_DEPTH];
   logic [CNT_W-1:0]       cnt_ff [2];
   logic [CNT_W-1:0]       cnt_in [2];
   logic [11:0]            lev_ff [2];
   logic [11:0]            lev_in [2];
   logic [12:0]            acc_ff, acc_in;
   logic [4:0]             div_ff, div_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   paft_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [2:0]  sel;
   logic [11:0] wdata;
   logic [1:0]  push, full, empty;
   logic [15:0] read_val;
   logic [11:0] period;
   logic [12:0] acc_sub;
   logic [6:0]  cyc_c;
   logic [13:0] sum;
   logic        expire, out_free;

   assign sel      = req_ff.reg_offset[3:1];
   assign wdata    = req_ff.write_data[11:0];
   assign push[0]  = cmd.do_write && (sel == paft_pkg::REG_LEFT || sel == paft_pkg::REG_MONO);
   assign push[1]  = cmd.do_write && (sel == paft_pkg::REG_RIGHT || sel == paft_pkg::REG_MONO);
   assign full[0]  = cnt_ff[0] == CNT_FULL;
   assign full[1]  = cnt_ff[1] == CNT_FULL;
   assign empty[0] = cnt_ff[0] == '0;
   assign empty[1] = cnt_ff[1] == '0;
   assign period   = cycle_ff - 12'd1;
   assign acc_sub  = acc_ff - {1'b0, period};
   assign cyc_c    = ({1'b0, req_ff.cycles} > CYC_MAX) ? CYC_MAX : {1'b0, req_ff.cycles};
   assign sum      = {1'b0, acc_ff} + {7'd0, cyc_c};
   assign expire   = div_ff <= 5'd1;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sts.kind       = req_ff.kind;
   assign sts.enabled    = (cycle_ff > 12'd1) && (ctrl_ff[3:0] != 4'd0);
   assign sts.more       = acc_ff >= {1'b0, period};
   assign sts.more_after = acc_sub >= {1'b0, period};
   assign sts.out_free   = out_free;

   always_comb begin
      case (sel)
         paft_pkg::REG_CTRL:  read_val = {4'd0, ctrl_ff};
         paft_pkg::REG_CYCLE: read_val = {4'd0, cycle_ff};
         paft_pkg::REG_LEFT:
            read_val = (full[0] ? paft_pkg::STAT_FULL : 16'd0) |
                       (empty[0] ? paft_pkg::STAT_EMPTY : 16'd0);
         paft_pkg::REG_RIGHT:
            read_val = (full[1] ? paft_pkg::STAT_FULL : 16'd0) |
                       (empty[1] ? paft_pkg::STAT_EMPTY : 16'd0);
         paft_pkg::REG_MONO:
            read_val = ((full[0] || full[1]) ? paft_pkg::STAT_FULL : 16'd0) |
                       ((empty[0] && empty[1]) ? paft_pkg::STAT_EMPTY : 16'd0);
         default: read_val = 16'd0;
      endcase
   end

   // Queues: push drops oldest when full; pop on each emitted period when not empty
   always_comb begin
      for (int s = 0; s < 2; s++) begin
         q_in[s]   = q_ff[s];
         cnt_in[s] = cnt_ff[s];
         lev_in[s] = lev_ff[s];
         if (push[s]) begin
            if (full[s]) begin
               for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_in[s][i] = q_ff[s][i + 1];
               q_in[s][QUEUE_DEPTH-1] = wdata;
            end else begin
               q_in[s][cnt_ff[s][IDX_W-1:0]] = wdata;
               cnt_in[s] = cnt_ff[s] + 1'b1;
            end
         end else if (cmd.emit && !empty[s]) begin
            lev_in[s] = q_ff[s][0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) q_in[s][i] = q_ff[s][i + 1];
            cnt_in[s] = cnt_ff[s] - 1'b1;
         end
      end
   end

   always_comb begin
      ctrl_in  = ctrl_ff;
      cycle_in = cycle_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      if (cmd.do_write && sel == paft_pkg::REG_CTRL) begin
         ctrl_in = wdata & paft_pkg::CTRL_MASK;
         div_in  = paft_pkg::div_reload(wdata[11:8]);
      end
      if (cmd.do_write && sel == paft_pkg::REG_CYCLE) cycle_in = wdata;
      if (cmd.tick_start) acc_in = sum[13] ? paft_pkg::ACC_MAX : sum[12:0];
      if (cmd.emit) begin
         acc_in = acc_sub;
         div_in = expire ? paft_pkg::div_reload(ctrl_ff[11:8]) : div_ff - 5'd1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_read) begin
         rsp_in           = '0;
         rsp_in.read_data = read_val;
         rsp_in.last      = 1'b1;
         rsp_valid_in     = 1'b1;
      end else if (cmd.emit) begin
         rsp_in              = '0;
         rsp_in.result_kind  = 1'b1;
         rsp_in.left_sample  = lev_in[0];
         rsp_in.right_sample = lev_in[1];
         rsp_in.timer_irq    = expire;
         rsp_in.dma_request  = expire && ctrl_ff[paft_pkg::CTRL_RTP];
         rsp_in.last         = cmd.last;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         cycle_ff     <= '0;
         cnt_ff[0]    <= '0;
         cnt_ff[1]    <= '0;
         lev_ff[0]    <= '0;
         lev_ff[1]    <= '0;
         acc_ff       <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl_in;
         cycle_ff     <= cycle_in;
         cnt_ff       <= cnt_in;
         lev_ff       <= lev_in;
         acc_ff       <= acc_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_word;
      q_ff   <= q_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// File: hdl/pwm_audio_fifo_timer_core.sv
// Stereo PWM audio unit with sample queues and interrupt divider: top level.
// Depends on paft_pkg, paft_ctrl and paft_dp.
//
// Each word on req_ is a register read, a register write or a time tick. A read
// or write is captured, then executed, and a read returns one rsp_ word. A tick
// is captured, then executed; an enabled tick then enters the period state, which
// emits sample pairs while the rsp_ side is free, up to the lesser of
// MAX_TICK_CYCLES and 32 pairs, and leaves at once when no period is due. The
// pair count in the controller bounds that loop, a stalled rsp_ side holds it, and
// req_ is stalled until the item is done. The last word of each item carries last.
module pwm_audio_fifo_timer_core #(
   parameter int QUEUE_DEPTH     = paft_pkg::DEF_QUEUE_DEPTH,
   parameter int MAX_TICK_CYCLES = paft_pkg::DEF_MAX_TICK_CYCLES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  paft_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output paft_pkg::rsp_word_type rsp_word
);

   paft_pkg::cmd_type cmd;
   paft_pkg::sts_type sts;

   paft_ctrl #(
      .MAX_TICK_CYCLES (MAX_TICK_CYCLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   paft_dp #(
      .QUEUE_DEPTH     (QUEUE_DEPTH),
      .MAX_TICK_CYCLES (MAX_TICK_CYCLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.load_read) |-> sts.out_free)
      else $error("result loaded while result register still held");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.load_read))
      else $error("read and sample pair loaded together");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !cmd.capture))
      else $error("new word accepted while an item is in progress");

endmodule

// File: tb/paft_tb_pkg.sv
`timescale 1ns / 100ps
// paft_tb_pkg: scoreboard for the PWM audio FIFO timer bench. It tracks registers,
// sample FIFOs, accumulator and divider, and keeps the rsp_ words still to arrive.
// Depends on paft_pkg.
package paft_tb_pkg;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic RESULT_READ = 1'b0;
   localparam logic RESULT_PAIR = 1'b1;
   localparam int PAIRS_PER_TICK =
      (paft_pkg::DEF_MAX_TICK_CYCLES < paft_pkg::RESULT_LIMIT) ?
      paft_pkg::DEF_MAX_TICK_CYCLES : paft_pkg::RESULT_LIMIT;

   class audio_scoreboard;
      logic [11:0] ctrl_reg = '0;
      logic [11:0] cycle_reg = '0;
      logic [11:0] left_fifo[$];
      logic [11:0] right_fifo[$];
      logic [11:0] left_out = '0;
      logic [11:0] right_out = '0;
      logic [12:0] cycle_acc = '0;
      logic [4:0]  div_left = '0;
      paft_pkg::rsp_word_type expected_words[$];
      int errors = 0;

      function int pending();
         return expected_words.size();
      endfunction

      function void add_expected(paft_pkg::rsp_word_type r);
         expected_words.insert(expected_words.size(), r);
      endfunction

      function logic [4:0] reload_value();
         return (ctrl_reg[11:8] == 4'h0) ? paft_pkg::DIV_MAX : {1'b0, ctrl_reg[11:8]};
      endfunction

      function logic [15:0] fifo_status(bit full, bit empty);
         return (full ? paft_pkg::STAT_FULL : 16'h0) | (empty ? paft_pkg::STAT_EMPTY : 16'h0);
      endfunction

      // a full FIFO drops its oldest entry
      function void push_sample(bit to_left, bit to_right, logic [11:0] sample);
         if (to_left) begin
            if (left_fifo.size() >= paft_pkg::DEF_QUEUE_DEPTH) void'(left_fifo.pop_front());
            left_fifo.insert(left_fifo.size(), sample);
         end
         if (to_right) begin
            if (right_fifo.size() >= paft_pkg::DEF_QUEUE_DEPTH) void'(right_fifo.pop_front());
            right_fifo.insert(right_fifo.size(), sample);
         end
      endfunction

      function void run_tick(logic [5:0] cycles);
         paft_pkg::rsp_word_type r;
         int period;
         int acc;
         int emitted;
         bit expire;
         if (cycle_reg <= 1 || ctrl_reg[3:0] == 4'h0) return;
         period = cycle_reg - 1;
         acc = cycle_acc + ((cycles > paft_pkg::DEF_MAX_TICK_CYCLES) ?
                            paft_pkg::DEF_MAX_TICK_CYCLES : cycles);
         if (acc > int'(paft_pkg::ACC_MAX)) acc = int'(paft_pkg::ACC_MAX);
         emitted = 0;
         while (acc >= period && emitted < PAIRS_PER_TICK) begin
            acc -= period;
            if (left_fifo.size() != 0) left_out = left_fifo.pop_front();
            if (right_fifo.size() != 0) right_out = right_fifo.pop_front();
            expire = (div_left <= 1);
            div_left = expire ? reload_value() : div_left - 5'd1;
            emitted++;
            r = '0;
            r.result_kind = RESULT_PAIR;
            r.left_sample = left_out;
            r.right_sample = right_out;
            r.timer_irq = expire;
            r.dma_request = expire && ctrl_reg[paft_pkg::CTRL_RTP];
            r.last = !(acc >= period && emitted < PAIRS_PER_TICK);
            add_expected(r);
         end
         cycle_acc = acc[12:0];
      endfunction

      function void note_input(paft_pkg::req_word_type w);
         paft_pkg::rsp_word_type r;
         logic [2:0] sel;
         sel = w.reg_offset[3:1];
         case (w.kind)
            paft_pkg::KIND_READ: begin
               r = '0;
               r.result_kind = RESULT_READ;
               r.last = 1'b1;
               case (sel)
                  paft_pkg::REG_CTRL:  r.read_data = {4'h0, ctrl_reg};
                  paft_pkg::REG_CYCLE: r.read_data = {4'h0, cycle_reg};
                  paft_pkg::REG_LEFT:
                     r.read_data = fifo_status(left_fifo.size() >= paft_pkg::DEF_QUEUE_DEPTH,
                                               left_fifo.size() == 0);
                  paft_pkg::REG_RIGHT:
                     r.read_data = fifo_status(right_fifo.size() >= paft_pkg::DEF_QUEUE_DEPTH,
                                               right_fifo.size() == 0);
                  paft_pkg::REG_MONO:
                     r.read_data = fifo_status(
                        left_fifo.size() >= paft_pkg::DEF_QUEUE_DEPTH ||
                        right_fifo.size() >= paft_pkg::DEF_QUEUE_DEPTH,
                        left_fifo.size() == 0 && right_fifo.size() == 0);
                  default:   r.read_data = '0;
               endcase
               add_expected(r);
            end
            paft_pkg::KIND_WRITE: begin
               case (sel)
                  paft_pkg::REG_CTRL: begin
                     ctrl_reg = w.write_data[11:0] & paft_pkg::CTRL_MASK;
                     div_left = reload_value();
                  end
                  paft_pkg::REG_CYCLE: cycle_reg = w.write_data[11:0];
                  paft_pkg::REG_LEFT:  push_sample(1'b1, 1'b0, w.write_data[11:0]);
                  paft_pkg::REG_RIGHT: push_sample(1'b0, 1'b1, w.write_data[11:0]);
                  paft_pkg::REG_MONO:  push_sample(1'b1, 1'b1, w.write_data[11:0]);
                  default: ;
               endcase
            end
            paft_pkg::KIND_TICK: run_tick(w.cycles);
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
         $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_field(string what, logic [15:0] got, logic [15:0] want);
         if (got !== want) report_mismatch(what, got, want);
      endtask

      task check_result(paft_pkg::rsp_word_type got);
         paft_pkg::rsp_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("word with none pending", got.read_data, 16'h0);
            return;
         end
         want = expected_words.pop_front();
         check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
         check_field("read_data", got.read_data, want.read_data);
         check_field("left_sample", 16'(got.left_sample), 16'(want.left_sample));
         check_field("right_sample", 16'(got.right_sample), 16'(want.right_sample));
         check_field("timer_irq", 16'(got.timer_irq), 16'(want.timer_irq));
         check_field("dma_request", 16'(got.dma_request), 16'(want.dma_request));
         check_field("last", 16'(got.last), 16'(want.last));
      endtask
   endclass

endpackage

// File: tb/tb_pwm_audio_fifo_timer_core.sv
`timescale 1ns / 100ps
// tb_pwm_audio_fifo_timer_core: directed then random reads, writes and ticks into
// the PWM audio FIFO timer, idling and stalling on both channels.
// Depends on paft_pkg, paft_tb_pkg and pwm_audio_fifo_timer_core.
module tb_pwm_audio_fifo_timer_core;

   localparam int RANDOM_ITEMS = 510;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   paft_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   paft_pkg::rsp_word_type rsp_word;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit hold_on = 1'b0;
   event hold_trigger;
   paft_tb_pkg::audio_scoreboard sb;

   pwm_audio_fifo_timer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_on || ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // long receiver hold-off so the block backs up into req_stall
   always begin
      @(hold_trigger);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
   end

   function automatic paft_pkg::req_word_type make_word(logic [1:0] kind, logic [3:0] offset,
                                                        logic [15:0] data, logic [5:0] cycles);
      paft_pkg::req_word_type w;
      w.kind = kind;
      w.reg_offset = offset;
      w.write_data = data;
      w.cycles = cycles;
      return w;
   endfunction

   task automatic send_word(input paft_pkg::req_word_type w);
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_input(w);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      int i;
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_CTRL, 1'b0}, 16'hFFFF, 6'd63));
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_CYCLE, 1'b1}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_MONO, 1'b1}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_READ, 4'hE, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd32));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CTRL, 1'b0}, 16'hFFFF, 6'd0));
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_CTRL, 1'b1}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CYCLE, 1'b1}, 16'hFFFF, 6'd0));
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_CYCLE, 1'b0}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_LEFT, 1'b0}, 16'hFFFF, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_RIGHT, 1'b1}, 16'h0000, 6'd0));
      // overfill both FIFOs
      for (i = 0; i < 3; i++) begin
         send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_MONO, 1'b0},
                             16'h1234 + 16'(i * 16'h3333), 6'd0));
      end
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_LEFT, 1'b0}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_RIGHT, 1'b0}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_READ, {paft_pkg::REG_MONO, 1'b0}, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, 4'hC, 16'hFFFF, 6'd0));
      send_word(make_word(paft_tb_pkg::KIND_UNUSED, {paft_pkg::REG_CTRL, 1'b0}, 16'h0000,
                          6'd32));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CYCLE, 1'b0}, 16'h0002, 6'd0));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd63));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CTRL, 1'b0}, 16'h0001, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CYCLE, 1'b0}, 16'h0005, 6'd0));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd3));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd1));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CYCLE, 1'b0}, 16'h0001, 6'd0));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd32));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CTRL, 1'b0}, 16'h0F00, 6'd0));
      send_word(make_word(paft_pkg::KIND_WRITE, {paft_pkg::REG_CYCLE, 1'b0}, 16'h0003, 6'd0));
      send_word(make_word(paft_pkg::KIND_TICK, 4'h0, 16'h0000, 6'd32));
   endtask

   task automatic send_random_item();
      paft_pkg::req_word_type w;
      int pick;
      int target;
      logic [2:0] sel;
      w = make_word(paft_pkg::KIND_READ, 4'($urandom_range(15)), 16'($urandom()),
                    6'($urandom_range(63)));
      pick = $urandom_range(99);
      if (pick < 22) begin
         w.kind = paft_pkg::KIND_READ;
      end else if (pick < 62) begin
         w.kind = paft_pkg::KIND_WRITE;
         target = $urandom_range(99);
         if (target < 8) begin
            sel = paft_pkg::REG_CTRL;
         end else if (target < 16) begin
            sel = paft_pkg::REG_CYCLE;
            if ($urandom_range(99) < 85) w.write_data = 16'($urandom_range(2, 40));
         end else if (target < 45) begin
            sel = paft_pkg::REG_LEFT;
         end else if (target < 74) begin
            sel = paft_pkg::REG_RIGHT;
         end else if (target < 92) begin
            sel = paft_pkg::REG_MONO;
         end else begin
            sel = 3'($urandom_range(int'(paft_pkg::REG_MONO) + 1, 7));
         end
         w.reg_offset[3:1] = sel;
      end else if (pick < 96) begin
         w.kind = paft_pkg::KIND_TICK;
         if ($urandom_range(99) < 90)
            w.cycles = 6'($urandom_range(paft_pkg::DEF_MAX_TICK_CYCLES));
      end else begin
         w.kind = paft_tb_pkg::KIND_UNUSED;
      end
      send_word(w);
   endtask

   initial begin
      int i;
      sb = new;
      req_idle_pct = 12;
      rsp_idle_pct = 60;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drain();

      for (i = 0; i < RANDOM_ITEMS / 3; i++) begin
         if (i == 40) -> hold_trigger;
         send_random_item();
      end
      wait_drain();

      req_idle_pct = 60;
      rsp_idle_pct = 12;
      for (i = 0; i < RANDOM_ITEMS / 3; i++) send_random_item();
      wait_drain();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      for (i = 0; i < RANDOM_ITEMS / 3; i++) send_random_item();
      wait_drain();

      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
